FILE: rtl/uv_sphere_vertex_generator_top_macros.svh
// Assertion macros shared by the vertex generator RTL.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/uvs_pkg.sv
package uvs_pkg;

   // Largest section count; larger register values saturate to this.
   localparam int MAX_SECTIONS = 64;
   // Table holds entries for residuals 0 .. MAX_SECTIONS inclusive.
   localparam int TAB_DEPTH    = MAX_SECTIONS + 1;
   localparam int ADDR_W       = $clog2(TAB_DEPTH);
   // Q30 magnitude in [0, 2^30].
   localparam int MAG_W        = 31;
   localparam int SECT_W       = 7;
   localparam int RAD_W        = 16;
   localparam int COORD_W      = 17;
   localparam int NUM_READS    = 6;

   // Register indexes of the configuration port.
   localparam logic [0:0] CSR_RADIUS   = 1'b0;
   localparam logic [0:0] CSR_SECTIONS = 1'b1;

   typedef logic [ADDR_W-1:0] tab_addr_type;
   typedef logic [MAG_W-1:0]  tab_mag_type;

   // Angle reduced to a quadrant and a residual numerator.
   typedef struct packed {
      logic [1:0]        quad;
      logic [SECT_W-1:0] resid;
   } reduced_type;

   // Table lookups and signs for the sine and cosine of one angle.
   typedef struct packed {
      tab_addr_type sin_addr;
      tab_addr_type cos_addr;
      logic         sin_neg;
      logic         cos_neg;
   } angle_type;

   // Read request toward the sine table.
   typedef struct packed {
      logic                          en;
      tab_addr_type [NUM_READS-1:0]  addr;
   } tab_rd_type;

   // Reduce v (below 4*n) modulo n, counting the quadrant.
   function automatic reduced_type reduce(input logic [7:0] v, input logic [SECT_W-1:0] n);
      reduced_type rd;
      logic [7:0]  acc;
      acc     = v;
      rd.quad = 2'd0;
      for (int s = 0; s < 3; s++) begin
         if (acc >= {1'b0, n}) begin
            acc     = acc - {1'b0, n};
            rd.quad = rd.quad + 2'd1;
         end
      end
      rd.resid = acc[SECT_W-1:0];
      return rd;
   endfunction

   // Map a reduced angle onto table addresses and signs.
   function automatic angle_type angle_of(input reduced_type rd, input logic [SECT_W-1:0] n);
      angle_type    a;
      tab_addr_type fwd;
      tab_addr_type rev;
      fwd        = ADDR_W'(rd.resid);
      rev        = ADDR_W'(n - rd.resid);
      a.sin_addr = rd.quad[0] ? rev : fwd;
      a.cos_addr = rd.quad[0] ? fwd : rev;
      a.sin_neg  = rd.quad[1];
      a.cos_neg  = rd.quad[1] ^ rd.quad[0];
      return a;
   endfunction

endpackage

FILE: rtl/uvs_req_if.sv
interface uvs_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] ring_index;
   logic [6:0] slice_index;

   modport source (output valid, ring_index, slice_index, input ready);
   modport sink (input valid, ring_index, slice_index, output ready);
endinterface

FILE: rtl/uvs_rsp_if.sv
interface uvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] lower_x;
   logic signed [16:0] lower_y;
   logic signed [16:0] lower_z;
   logic signed [16:0] upper_x;
   logic signed [16:0] upper_y;
   logic signed [16:0] upper_z;
   logic               index_error;

   modport source (output valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
                   index_error, input ready);
   modport sink (input valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
                 index_error, output ready);
endinterface

FILE: rtl/uvs_sin_table.sv
module uvs_sin_table import uvs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [SECT_W-1:0]             sections,
   input  logic                          refill,
   output logic                          busy,
   input  tab_rd_type                    rd,
   output tab_mag_type [NUM_READS-1:0]   rd_data
);

   localparam int DIV_W  = 38;
   localparam int CNT_W  = $clog2(DIV_W);
   localparam int DVS_W  = 9;
   localparam int TERMS  = 9;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] HALF_Q30    = 64'd536870912;
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

   typedef enum logic [6:0] {
      FILL_IDLE  = 7'b0000001,
      FILL_START = 7'b0000010,
      FILL_DIVX  = 7'b0000100,
      FILL_SQ    = 7'b0001000,
      FILL_MUL   = 7'b0010000,
      FILL_DIVT  = 7'b0100000,
      FILL_ACC   = 7'b1000000
   } fill_state_type;

   // Divisor of the k-th series term: (2k)(2k+1).
   function automatic logic [DVS_W-1:0] term_div(input logic [3:0] k);
      int kk;
      kk = int'(k);
      return DVS_W'(2 * kk * (2 * kk + 1));
   endfunction

   fill_state_type         state_ff, state_in;
   logic [ADDR_W-1:0]      entry_ff, entry_in;
   logic [3:0]             k_ff, k_in;
   logic [31:0]            x2_ff, x2_in;
   logic [MAG_W-1:0]       term_ff, term_in;
   logic signed [33:0]     sum_ff, sum_in;
   logic [DVS_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       quo_ff, quo_in;
   logic [DVS_W-1:0]       dvs_ff, dvs_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic [31:0]            mul_a;
   logic [31:0]            mul_b;
   logic [63:0]            prod;
   logic [63:0]            prod_rnd;
   logic [DVS_W:0]         rem_sh;
   logic                   ge;
   logic [DVS_W-1:0]       rem_step;
   logic [DIV_W-1:0]       quo_step;
   logic                   div_last;
   logic signed [33:0]     sum_next;
   tab_mag_type            wr_data;
   logic                   wr_en;

   tab_mag_type mem_a [TAB_DEPTH];
   tab_mag_type mem_b [TAB_DEPTH];
   tab_mag_type mem_c [TAB_DEPTH];

   // Shared multiplier and its rounding to Q30.
   assign prod     = 64'(mul_a) * 64'(mul_b);
   assign prod_rnd = (prod + HALF_Q30) >> 30;

   // One restoring division step per cycle.
   assign rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
   assign ge       = rem_sh >= {1'b0, dvs_ff};
   assign rem_step = ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
   assign quo_step = {quo_ff[DIV_W-2:0], ge};
   assign div_last = cnt_ff == CNT_W'(DIV_W - 1);

   // Running series sum with the new term, then clamped to [0, 1].
   assign sum_next = k_ff[0] ? sum_ff - $signed({3'b000, quo_ff[MAG_W-1:0]})
                             : sum_ff + $signed({3'b000, quo_ff[MAG_W-1:0]});
   always_comb begin
      if (sum_next < 34'sd0) begin
         wr_data = '0;
      end else if (sum_next > ONE_Q30) begin
         wr_data = MAG_W'(ONE_Q30);
      end else begin
         wr_data = MAG_W'(sum_next);
      end
   end

   // Fill sequencer: residual angle, square, then nine series terms.
   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      k_in     = k_ff;
      x2_in    = x2_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      mul_a    = '0;
      mul_b    = '0;
      wr_en    = 1'b0;
      unique case (state_ff)
         FILL_IDLE: begin
         end
         FILL_START: begin
            mul_a    = 32'(entry_ff);
            mul_b    = 32'(HALF_PI_Q30);
            quo_in   = DIV_W'(prod + 64'(sections >> 1));
            rem_in   = '0;
            dvs_in   = DVS_W'(sections);
            cnt_in   = '0;
            state_in = FILL_DIVX;
         end
         FILL_DIVX, FILL_DIVT: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = state_ff == FILL_DIVX ? FILL_SQ : FILL_ACC;
            end
         end
         FILL_SQ: begin
            mul_a    = 32'(quo_ff[MAG_W-1:0]);
            mul_b    = 32'(quo_ff[MAG_W-1:0]);
            x2_in    = prod_rnd[31:0];
            term_in  = quo_ff[MAG_W-1:0];
            sum_in   = $signed({3'b000, quo_ff[MAG_W-1:0]});
            k_in     = 4'd1;
            state_in = FILL_MUL;
         end
         FILL_MUL: begin
            mul_a    = 32'(term_ff);
            mul_b    = x2_ff;
            quo_in   = DIV_W'(prod_rnd + 64'(term_div(k_ff) >> 1));
            rem_in   = '0;
            dvs_in   = term_div(k_ff);
            cnt_in   = '0;
            state_in = FILL_DIVT;
         end
         FILL_ACC: begin
            term_in = quo_ff[MAG_W-1:0];
            sum_in  = sum_next;
            if (k_ff == 4'(TERMS)) begin
               wr_en    = 1'b1;
               entry_in = entry_ff + ADDR_W'(1);
               state_in = (entry_ff == ADDR_W'(sections)) ? FILL_IDLE : FILL_START;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = FILL_MUL;
            end
         end
         default: begin
            state_in = FILL_START;
            entry_in = '0;
         end
      endcase
      if (refill) begin
         state_in = FILL_START;
         entry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FILL_START;
         entry_ff <= '0;
      end else begin
         state_ff <= state_in;
         entry_ff <= entry_in;
      end
      k_ff    <= k_in;
      x2_ff   <= x2_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = state_ff != FILL_IDLE;

   // Three identical copies give six read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[entry_ff] <= wr_data;
         mem_b[entry_ff] <= wr_data;
         mem_c[entry_ff] <= wr_data;
      end
      if (rd.en) begin
         rd_data[0] <= mem_a[rd.addr[0]];
         rd_data[1] <= mem_a[rd.addr[1]];
         rd_data[2] <= mem_b[rd.addr[2]];
         rd_data[3] <= mem_b[rd.addr[3]];
         rd_data[4] <= mem_c[rd.addr[4]];
         rd_data[5] <= mem_c[rd.addr[5]];
      end
   end

endmodule

FILE: rtl/uv_sphere_vertex_generator_top.sv
// UV-sphere vertex pair generator.
// The req_ch channel carries one transaction per quad-strip step: a ring index
// and a slice index. For each accepted transaction the rsp_ch channel returns
// the lower-edge and upper-edge vertices of that ring at the slice longitude,
// in signed Q4.12, plus an index error flag (coordinates then zero).
// Radius and section count are written on the csr_ port while no transaction
// is in flight. A section count write, and reset, start a fill of the sine
// table, one entry per residual 0..n; req_ch.ready stays low while it runs.
// A transaction passes through four register stages to rsp_ch.valid: table
// read (loaded at the accepting edge), radius product, longitude product,
// output register. One transaction enters per cycle while req_ch.ready is
// high; the pipeline has no internal loops.
// When rsp_ch.ready is low with a result waiting, every stage holds and
// req_ch.ready drops in the same cycle; nothing is dropped or repeated.
// Reset is synchronous and active high; it restores radius 1.0 and 20
// sections and empties the pipeline.
`include "uv_sphere_vertex_generator_top_macros.svh"

module uv_sphere_vertex_generator_top import uvs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   uvs_req_if.sink          req_ch,
   uvs_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [0:0]       csr_index,
   input  logic [RAD_W-1:0] csr_wdata
);

   logic [RAD_W-1:0]  radius_ff;
   logic [SECT_W-1:0] sections_ff;
   logic [SECT_W-1:0] sect_sat;
   logic              refill;
   logic              busy;
   logic              en;

   tab_rd_type                   rd;
   tab_mag_type [NUM_READS-1:0]  rd_data;

   angle_type         ang_lo;
   angle_type         ang_up;
   angle_type         ang_lon;
   logic [SECT_W-1:0] lon_pr;
   logic              bad0;
   logic [5:0]        neg0;

   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              bad1_ff, bad2_ff, bad3_ff;
   logic [5:0]        neg1_ff, neg2_ff, neg3_ff;

   logic [47:0]       t_lo_sum, t_up_sum, y_lo_sum, y_up_sum;
   logic [MAG_W-1:0]  t_lo_ff, t_up_ff;
   logic [COORD_W-1:0] y_lo2_ff, y_up2_ff, y_lo3_ff, y_up3_ff;
   tab_mag_type       lon_s2_ff, lon_c2_ff;

   logic [62:0]       xl_sum, zl_sum, xu_sum, zu_sum;
   logic [COORD_W-1:0] xl_ff, zl_ff, xu_ff, zu_ff;

   logic signed [COORD_W-1:0] lower_x_ff, lower_y_ff, lower_z_ff;
   logic signed [COORD_W-1:0] upper_x_ff, upper_y_ff, upper_z_ff;
   logic                      err_ff;

   // Configuration registers; the section count saturates.
   assign sect_sat = (csr_wdata[SECT_W-1:0] > SECT_W'(MAX_SECTIONS)) ?
                     SECT_W'(MAX_SECTIONS) : csr_wdata[SECT_W-1:0];
   assign refill   = csr_wr_en && (csr_index == CSR_SECTIONS);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RAD_W'(4096);
         sections_ff <= SECT_W'(20);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RADIUS:   radius_ff   <= csr_wdata;
            CSR_SECTIONS: sections_ff <= sect_sat;
            default: begin
            end
         endcase
      end
   end

   uvs_sin_table u_table (
      .clock    (clock),
      .reset    (reset),
      .sections (sections_ff),
      .refill   (refill),
      .busy     (busy),
      .rd       (rd),
      .rd_data  (rd_data)
   );

   // The whole pipeline advances unless a result waits at the output.
   assign en           = !v4_ff || rsp_ch.ready;
   assign req_ch.ready = en && !busy;

   // Index check and angle reduction of the incoming transaction.
   assign bad0   = ({1'b0, req_ch.ring_index} >= sections_ff) ||
                   (req_ch.slice_index > sections_ff);
   assign lon_pr = (req_ch.slice_index == sections_ff) ? '0 : req_ch.slice_index;
   assign ang_lo  = angle_of(reduce({1'b0, req_ch.ring_index, 1'b0}, sections_ff),
                             sections_ff);
   assign ang_up  = angle_of(reduce(8'({1'b0, req_ch.ring_index, 1'b0} + 8'd2),
                                    sections_ff), sections_ff);
   assign ang_lon = angle_of(reduce(8'({lon_pr, 2'b00}), sections_ff), sections_ff);

   // Sign of x, y, z for the lower vertex, then the upper vertex.
   assign neg0 = {ang_up.sin_neg ^ ang_lon.sin_neg, !ang_up.cos_neg,
                  ang_up.sin_neg ^ ang_lon.cos_neg,
                  ang_lo.sin_neg ^ ang_lon.sin_neg, !ang_lo.cos_neg,
                  ang_lo.sin_neg ^ ang_lon.cos_neg};

   assign rd.en      = en;
   assign rd.addr[0] = ang_lo.sin_addr;
   assign rd.addr[1] = ang_lo.cos_addr;
   assign rd.addr[2] = ang_up.sin_addr;
   assign rd.addr[3] = ang_up.cos_addr;
   assign rd.addr[4] = ang_lon.sin_addr;
   assign rd.addr[5] = ang_lon.cos_addr;

   // Radius products: ring sine term t and the y coordinates.
   assign t_lo_sum = 48'(radius_ff) * 48'(rd_data[0]) + 48'd32768;
   assign t_up_sum = 48'(radius_ff) * 48'(rd_data[2]) + 48'd32768;
   assign y_lo_sum = 48'(radius_ff) * 48'(rd_data[1]) + 48'd536870912;
   assign y_up_sum = 48'(radius_ff) * 48'(rd_data[3]) + 48'd536870912;

   // Longitude products for x and z.
   assign xl_sum = 63'(t_lo_ff) * 63'(lon_c2_ff) + (63'd1 << 43);
   assign zl_sum = 63'(t_lo_ff) * 63'(lon_s2_ff) + (63'd1 << 43);
   assign xu_sum = 63'(t_up_ff) * 63'(lon_c2_ff) + (63'd1 << 43);
   assign zu_sum = 63'(t_up_ff) * 63'(lon_s2_ff) + (63'd1 << 43);

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid && req_ch.ready;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (en) begin
         bad1_ff   <= bad0;
         neg1_ff   <= neg0;

         bad2_ff   <= bad1_ff;
         neg2_ff   <= neg1_ff;
         t_lo_ff   <= t_lo_sum[46:16];
         t_up_ff   <= t_up_sum[46:16];
         y_lo2_ff  <= y_lo_sum[46:30];
         y_up2_ff  <= y_up_sum[46:30];
         lon_s2_ff <= rd_data[4];
         lon_c2_ff <= rd_data[5];

         bad3_ff   <= bad2_ff;
         neg3_ff   <= neg2_ff;
         xl_ff     <= xl_sum[60:44];
         zl_ff     <= zl_sum[60:44];
         xu_ff     <= xu_sum[60:44];
         zu_ff     <= zu_sum[60:44];
         y_lo3_ff  <= y_lo2_ff;
         y_up3_ff  <= y_up2_ff;

         err_ff     <= bad3_ff;
         lower_x_ff <= bad3_ff ? '0 : $signed(neg3_ff[0] ? -xl_ff : xl_ff);
         lower_y_ff <= bad3_ff ? '0 : $signed(neg3_ff[1] ? -y_lo3_ff : y_lo3_ff);
         lower_z_ff <= bad3_ff ? '0 : $signed(neg3_ff[2] ? -zl_ff : zl_ff);
         upper_x_ff <= bad3_ff ? '0 : $signed(neg3_ff[3] ? -xu_ff : xu_ff);
         upper_y_ff <= bad3_ff ? '0 : $signed(neg3_ff[4] ? -y_up3_ff : y_up3_ff);
         upper_z_ff <= bad3_ff ? '0 : $signed(neg3_ff[5] ? -zu_ff : zu_ff);
      end
   end

   assign rsp_ch.valid       = v4_ff;
   assign rsp_ch.lower_x     = lower_x_ff;
   assign rsp_ch.lower_y     = lower_y_ff;
   assign rsp_ch.lower_z     = lower_z_ff;
   assign rsp_ch.upper_x     = upper_x_ff;
   assign rsp_ch.upper_y     = upper_y_ff;
   assign rsp_ch.upper_z     = upper_z_ff;
   assign rsp_ch.index_error = err_ff;

   // A section count write always starts a table fill.
   `UVS_ASSERT_NEXT(a_refill_busy, refill, busy, "section write did not start table fill")
   // An error result carries zero coordinates.
   `UVS_ASSERT_SAME(a_err_zero, rsp_ch.valid && rsp_ch.index_error,
      (rsp_ch.lower_x == 0) && (rsp_ch.lower_y == 0) && (rsp_ch.lower_z == 0) &&
      (rsp_ch.upper_x == 0) && (rsp_ch.upper_y == 0) && (rsp_ch.upper_z == 0),
      "error result with nonzero coordinates")
   // A stalled pipeline keeps its inner transactions.
   `UVS_ASSERT_NEXT(a_stall_hold, v3_ff && !en, v3_ff, "stage three lost a transaction")

endmodule
